>>> design/bis_pkg.sv
// shared types and constants for the bilinear image sampler
// no dependencies; imported by bilinear_image_sampler and the testbench
`default_nettype none

package bis_pkg;

   localparam int COL_BITS       = 8;
   localparam int ROW_BITS       = 8;
   localparam int PIX_BITS       = 8;
   localparam int FRAC_BITS      = 8;
   localparam int COORD_BITS     = 17;
   localparam int SIZE_BITS      = 9;
   localparam int VALUE_BITS     = 16;
   localparam int NUM_BANKS      = 4;
   localparam int BANK_SEL_BITS  = 2;
   localparam int BANK_ADDR_BITS = (COL_BITS - 1) + (ROW_BITS - 1);
   localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [SIZE_BITS-1:0] MAX_WIDTH  = SIZE_BITS'(256);
   localparam logic [SIZE_BITS-1:0] MAX_HEIGHT = SIZE_BITS'(256);

   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_SAMPLE_MODE   = 2'd2;
   localparam logic [1:0] REG_OUTSIDE_VALUE = 2'd3;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   localparam logic MODE_BILINEAR = 1'b0;
   localparam logic MODE_NEAREST  = 1'b1;

   typedef struct packed {
      logic                 oob;
      logic                 xlast;
      logic                 ylast;
      logic                 c0_odd;
      logic                 r0_odd;
      logic [FRAC_BITS-1:0] u;
      logic [FRAC_BITS-1:0] v;
   } fetch_meta_type;

   typedef struct packed {
      logic                 oob;
      logic [FRAC_BITS-1:0] v;
   } blend_meta_type;

endpackage

`default_nettype wire

>>> design/bilinear_image_sampler.sv
// Bilinear image sampler: the image is held in four banks split by row and
// column parity, so the four neighbors of any point are read together.
// A write transaction stores one pixel (no result). A sample transaction
// returns one result after the bank read and both blends. One transaction is
// taken every cycle; the only back pressure is a stalled result reaching the
// first pipeline stage. Each bank is a single synchronous memory with one
// write and one read port, and a cycle carries either a write or a sample,
// so no forwarding is needed. Pixels are undefined until written; there is
// no clearing pass after reset. Configuration registers sit behind the csr_
// port and are to be written only while no transaction is in flight.
// depends on bis_pkg
`default_nettype none

module bilinear_image_sampler
   import bis_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,

   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire                      req_action,
   input  wire  [COL_BITS-1:0]      req_pixel_column,
   input  wire  [ROW_BITS-1:0]      req_pixel_row,
   input  wire  [PIX_BITS-1:0]      req_pixel_value,
   input  wire  [COORD_BITS-1:0]    req_coord_x,
   input  wire  [COORD_BITS-1:0]    req_coord_y,

   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [VALUE_BITS-1:0]    rsp_sample_value,
   output logic                     rsp_out_of_bounds,

   input  wire                      csr_psel,
   input  wire                      csr_penable,
   input  wire                      csr_pwrite,
   input  wire  [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire  [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // configuration registers
   logic [SIZE_BITS-1:0]  width_ff, height_ff;
   logic                  mode_ff;
   logic [VALUE_BITS-1:0] outside_ff;
   logic                  csr_wr;
   logic [1:0]            csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= MAX_WIDTH;
         height_ff  <= MAX_HEIGHT;
         mode_ff    <= MODE_BILINEAR;
         outside_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_IMAGE_WIDTH:   width_ff   <= csr_pwdata[SIZE_BITS-1:0];
            REG_IMAGE_HEIGHT:  height_ff  <= csr_pwdata[SIZE_BITS-1:0];
            REG_SAMPLE_MODE:   mode_ff    <= csr_pwdata[0];
            REG_OUTSIDE_VALUE: outside_ff <= csr_pwdata[VALUE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_IMAGE_WIDTH:   csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT:  csr_prdata = CSR_DATA_BITS'(height_ff);
         REG_SAMPLE_MODE:   csr_prdata = CSR_DATA_BITS'(mode_ff);
         REG_OUTSIDE_VALUE: csr_prdata = CSR_DATA_BITS'(outside_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // pipeline flow control
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic ready1, ready2, ready3;
   logic req_acc, wr_en, rd_en;

   assign ready3    = !v3_ff || !rsp_stall;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = !ready1;
   assign req_acc   = req_valid && ready1;
   assign wr_en     = req_acc && (req_action == ACTION_WRITE);
   assign rd_en     = req_acc && (req_action == ACTION_SAMPLE);

   assign v1_in = ready1 ? rd_en : v1_ff;
   assign v2_in = ready2 ? v1_ff : v2_ff;
   assign v3_in = ready3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage 0: bounds, base pixel and fractions
   logic [SIZE_BITS-1:0]    w_eff, h_eff;
   logic [COORD_BITS:0]     nx_sum, ny_sum;
   logic [SIZE_BITS:0]      nx, ny;
   logic                    bl_oob, nn_oob;
   logic [SIZE_BITS-1:0]    xi, yi;
   logic [COL_BITS-1:0]     c0, c0p1;
   logic [ROW_BITS-1:0]     r0, r0p1;
   fetch_meta_type          meta0, meta1_ff;

   assign w_eff = (width_ff  > MAX_WIDTH)  ? MAX_WIDTH  : width_ff;
   assign h_eff = (height_ff > MAX_HEIGHT) ? MAX_HEIGHT : height_ff;

   assign nx_sum = {1'b0, req_coord_x} + (COORD_BITS+1)'(1 << (FRAC_BITS - 1));
   assign ny_sum = {1'b0, req_coord_y} + (COORD_BITS+1)'(1 << (FRAC_BITS - 1));
   assign nx     = nx_sum[COORD_BITS:FRAC_BITS];
   assign ny     = ny_sum[COORD_BITS:FRAC_BITS];

   assign bl_oob = (req_coord_x < COORD_BITS'(1 << FRAC_BITS))
                || (req_coord_x > {w_eff, FRAC_BITS'(0)})
                || (req_coord_y < COORD_BITS'(1 << FRAC_BITS))
                || (req_coord_y > {h_eff, FRAC_BITS'(0)});
   assign nn_oob = (nx == '0) || (nx > {1'b0, w_eff})
                || (ny == '0) || (ny > {1'b0, h_eff});

   always_comb begin
      if (mode_ff == MODE_NEAREST) begin
         xi          = nx[SIZE_BITS-1:0];
         yi          = ny[SIZE_BITS-1:0];
         meta0.oob   = nn_oob;
         meta0.xlast = 1'b1;
         meta0.ylast = 1'b1;
         meta0.u     = '0;
         meta0.v     = '0;
      end else begin
         xi          = req_coord_x[COORD_BITS-1:FRAC_BITS];
         yi          = req_coord_y[COORD_BITS-1:FRAC_BITS];
         meta0.oob   = bl_oob;
         meta0.xlast = (req_coord_x[COORD_BITS-1:FRAC_BITS] == w_eff);
         meta0.ylast = (req_coord_y[COORD_BITS-1:FRAC_BITS] == h_eff);
         meta0.u     = req_coord_x[FRAC_BITS-1:0];
         meta0.v     = req_coord_y[FRAC_BITS-1:0];
      end
      c0           = COL_BITS'(xi - SIZE_BITS'(1));
      r0           = ROW_BITS'(yi - SIZE_BITS'(1));
      c0p1         = c0 + COL_BITS'(1);
      r0p1         = r0 + ROW_BITS'(1);
      meta0.c0_odd = c0[0];
      meta0.r0_odd = r0[0];
   end

   // pixel banks, indexed by {row parity, column parity}
   logic [BANK_ADDR_BITS-1:0] wr_addr;
   logic [BANK_SEL_BITS-1:0]  wr_bank;
   logic [BANK_ADDR_BITS-1:0] rd_addr [NUM_BANKS];
   logic [PIX_BITS-1:0]       bank_q  [NUM_BANKS];

   assign wr_addr = {req_pixel_row[ROW_BITS-1:1], req_pixel_column[COL_BITS-1:1]};
   assign wr_bank = {req_pixel_row[0], req_pixel_column[0]};

   always_comb begin
      for (int k = 0; k < NUM_BANKS; k++) begin
         rd_addr[k][COL_BITS-2:0] = k[0] ? c0[COL_BITS-1:1] : c0p1[COL_BITS-1:1];
         rd_addr[k][BANK_ADDR_BITS-1:COL_BITS-1] =
            k[1] ? r0[ROW_BITS-1:1] : r0p1[ROW_BITS-1:1];
      end
   end

   for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
      logic [PIX_BITS-1:0] mem [BANK_DEPTH];
      logic [PIX_BITS-1:0] q_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == BANK_SEL_BITS'(k))) begin
            mem[wr_addr] <= req_pixel_value;
         end
         if (rd_en) begin
            q_ff <= mem[rd_addr[k]];
         end
      end

      assign bank_q[k] = q_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         meta1_ff <= meta0;
      end
   end

   // stage 1: horizontal blend of both rows
   logic [PIX_BITS-1:0]    pa, pb, pc, pd, pb_use, pc_use, pd_use;
   logic signed [8:0]      diff_ab, diff_cd;
   logic signed [17:0]     prod_ab, prod_cd, t1_full, t2_full;
   logic [16:0]            t1_ff, t2_ff;
   blend_meta_type         meta2_ff;

   assign pa = bank_q[{meta1_ff.r0_odd,  meta1_ff.c0_odd}];
   assign pb = bank_q[{meta1_ff.r0_odd, ~meta1_ff.c0_odd}];
   assign pc = bank_q[{~meta1_ff.r0_odd,  meta1_ff.c0_odd}];
   assign pd = bank_q[{~meta1_ff.r0_odd, ~meta1_ff.c0_odd}];

   // neighbors past the last column or row carry zero weight
   assign pb_use = meta1_ff.xlast ? pa : pb;
   assign pc_use = meta1_ff.ylast ? pa : pc;
   assign pd_use = meta1_ff.xlast ? pc_use : (meta1_ff.ylast ? pb_use : pd);

   assign diff_ab = $signed({1'b0, pb_use}) - $signed({1'b0, pa});
   assign diff_cd = $signed({1'b0, pd_use}) - $signed({1'b0, pc_use});
   assign prod_ab = diff_ab * $signed({1'b0, meta1_ff.u});
   assign prod_cd = diff_cd * $signed({1'b0, meta1_ff.u});
   assign t1_full = $signed({2'b00, pa, FRAC_BITS'(0)}) + prod_ab;
   assign t2_full = $signed({2'b00, pc_use, FRAC_BITS'(0)}) + prod_cd;

   always_ff @(posedge clock) begin
      if (v1_ff && ready2) begin
         t1_ff        <= t1_full[16:0];
         t2_ff        <= t2_full[16:0];
         meta2_ff.oob <= meta1_ff.oob;
         meta2_ff.v   <= meta1_ff.v;
      end
   end

   // stage 2: vertical blend and output register
   logic signed [17:0] diff_t;
   logic signed [26:0] prod_t, p_full;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_oob_ff;

   assign diff_t = $signed({1'b0, t2_ff}) - $signed({1'b0, t1_ff});
   assign prod_t = diff_t * $signed({1'b0, meta2_ff.v});
   assign p_full = $signed({2'b00, t1_ff, FRAC_BITS'(0)}) + prod_t;

   always_ff @(posedge clock) begin
      if (v2_ff && ready3) begin
         rsp_oob_ff   <= meta2_ff.oob;
         rsp_value_ff <= meta2_ff.oob ? outside_ff
                                      : p_full[VALUE_BITS+FRAC_BITS-1:FRAC_BITS];
      end
   end

   assign rsp_valid         = v3_ff;
   assign rsp_sample_value  = rsp_value_ff;
   assign rsp_out_of_bounds = rsp_oob_ff;

`ifndef SYNTHESIS
   a_stall_needs_full_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("input stalled with empty first stage");

   a_sample_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> v1_ff)
      else $error("accepted sample transaction lost");

   a_blocked_stage_holds: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !ready2 |=> v1_ff && $stable(meta1_ff))
      else $error("blocked fetch stage changed");

   a_oob_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_bounds |-> rsp_sample_value == outside_ff)
      else $error("out of bounds result without outside value");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      wr_en && !v1_ff |=> !v1_ff)
      else $error("write transaction produced a pipeline entry");
`endif

endmodule

`default_nettype wire

>>> sim/testbench.sv
// self-checking testbench for bilinear_image_sampler: mirrors the image and the csr
// registers, predicts every sample transaction and compares the results in order
// depends on bis_pkg and bilinear_image_sampler
module testbench
   import bis_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int OUT_FRAC = 8;
   localparam longint ONE = longint'(1) << FRAC_BITS;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  oob;
      logic                  unwritten;
   } sample_expect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_action = ACTION_WRITE;
   logic [COL_BITS-1:0]      req_pixel_column = '0;
   logic [ROW_BITS-1:0]      req_pixel_row = '0;
   logic [PIX_BITS-1:0]      req_pixel_value = '0;
   logic [COORD_BITS-1:0]    req_coord_x = '0;
   logic [COORD_BITS-1:0]    req_coord_y = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0]    rsp_sample_value;
   logic                     rsp_out_of_bounds;

   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   logic [PIX_BITS-1:0] image_mirror [0:65535];
   bit                  pixel_written [0:65535];
   bit                  read_miss;

   logic [SIZE_BITS-1:0]  cfg_width = MAX_WIDTH;
   logic [SIZE_BITS-1:0]  cfg_height = MAX_HEIGHT;
   logic                  cfg_mode = MODE_BILINEAR;
   logic [VALUE_BITS-1:0] cfg_outside = '0;

   sample_expect_type pending_samples [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int phase_count = 0;

   bilinear_image_sampler dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_pixel_column  (req_pixel_column),
      .req_pixel_row     (req_pixel_row),
      .req_pixel_value   (req_pixel_value),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_out_of_bounds (rsp_out_of_bounds),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic int eff_size(logic [SIZE_BITS-1:0] v);
      return (v > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(v);
   endfunction

   function automatic longint pixel_at(longint col, longint row);
      int idx;
      idx = int'(row) * int'(MAX_WIDTH) + int'(col);
      if (!pixel_written[idx]) read_miss = 1'b1;
      return longint'(image_mirror[idx]);
   endfunction

   function automatic sample_expect_type predict_sample(logic [COORD_BITS-1:0] cx,
                                                        logic [COORD_BITS-1:0] cy);
      sample_expect_type r;
      int w, h;
      longint xc, yc, x1, y1, u, v, a, b, c, d, t1, t2, p;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      xc = longint'(cx);
      yc = longint'(cy);
      r = '0;
      read_miss = 1'b0;
      if (cfg_mode == MODE_NEAREST) begin
         x1 = (xc + (ONE >> 1)) >> FRAC_BITS;
         y1 = (yc + (ONE >> 1)) >> FRAC_BITS;
         if (x1 < 1 || x1 > w || y1 < 1 || y1 > h) begin
            r.oob = 1'b1;
         end else begin
            r.value = VALUE_BITS'(pixel_at(x1 - 1, y1 - 1) << OUT_FRAC);
         end
      end else if (xc < ONE || xc > longint'(w) * ONE || yc < ONE || yc > longint'(h) * ONE) begin
         r.oob = 1'b1;
      end else begin
         x1 = xc >> FRAC_BITS;
         y1 = yc >> FRAC_BITS;
         u = xc & (ONE - 1);
         v = yc & (ONE - 1);
         if (x1 < w && y1 < h) begin
            a = pixel_at(x1 - 1, y1 - 1);
            b = pixel_at(x1, y1 - 1);
            c = pixel_at(x1 - 1, y1);
            d = pixel_at(x1, y1);
            t1 = a * ONE + (b - a) * u;
            t2 = c * ONE + (d - c) * u;
            p = t1 * ONE + (t2 - t1) * v;
         end else if (x1 < w) begin
            a = pixel_at(x1 - 1, y1 - 1);
            b = pixel_at(x1, y1 - 1);
            p = (a * ONE + (b - a) * u) * ONE;
         end else if (y1 < h) begin
            a = pixel_at(x1 - 1, y1 - 1);
            c = pixel_at(x1 - 1, y1);
            p = a * ONE * ONE + (c - a) * v * ONE;
         end else begin
            p = pixel_at(w - 1, h - 1) * ONE * ONE;
         end
         if (p < 0) p = 0;
         r.value = VALUE_BITS'(p >> (2 * FRAC_BITS - OUT_FRAC));
      end
      if (r.oob) r.value = cfg_outside;
      r.unwritten = read_miss;
      return r;
   endfunction

   function automatic logic [COORD_BITS-1:0] q98(int whole, int frac);
      return COORD_BITS'((whole << FRAC_BITS) | frac);
   endfunction

   function automatic logic [PIX_BITS-1:0] pick_pixel();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return PIX_BITS'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_coord(int limit);
      int top;
      top = (limit < 1) ? 1 : limit;
      case ($urandom_range(9))
         0: return COORD_BITS'($urandom_range(131071));
         1: return COORD_BITS'(top << FRAC_BITS);
         2: return COORD_BITS'((top << FRAC_BITS) + $urandom_range(1, 255));
         3: return COORD_BITS'($urandom_range(255));
         4: return COORD_BITS'($urandom_range(1, top) << FRAC_BITS);
         5: return COORD_BITS'(($urandom_range(1, top) << FRAC_BITS) |
                               ($urandom_range(1) ? 8'h80 : 8'h7F));
         default: return COORD_BITS'($urandom_range(256, (top << FRAC_BITS) + 255));
      endcase
   endfunction

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      if (mismatch_count < 200)
         $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
                  field, cycle_count, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      sample_expect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("result with no sample pending", '0, 32'(rsp_sample_value));
         end else begin
            want = pending_samples.pop_front();
            if (rsp_sample_value !== want.value)
               report_mismatch("sample_value", 32'(want.value), 32'(rsp_sample_value));
            if (rsp_out_of_bounds !== want.oob)
               report_mismatch("out_of_bounds", 32'(want.oob), 32'(rsp_out_of_bounds));
         end
      end
   end

   task automatic send_item(logic action, logic [COL_BITS-1:0] col, logic [ROW_BITS-1:0] row,
                            logic [PIX_BITS-1:0] val, logic [COORD_BITS-1:0] cx,
                            logic [COORD_BITS-1:0] cy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_pixel_column <= col;
      req_pixel_row <= row;
      req_pixel_value <= val;
      req_coord_x <= cx;
      req_coord_y <= cy;
      do @(posedge clock); while (req_stall);
      if (action == ACTION_WRITE) begin
         image_mirror[{row, col}] = val;
         pixel_written[{row, col}] = 1'b1;
      end else begin
         pending_samples.push_back(predict_sample(cx, cy));
      end
   endtask

   task automatic write_pixel(logic [COL_BITS-1:0] col, logic [ROW_BITS-1:0] row,
                              logic [PIX_BITS-1:0] val);
      send_item(ACTION_WRITE, col, row, val, COORD_BITS'($urandom_range(131071)),
                COORD_BITS'($urandom_range(131071)));
   endtask

   task automatic sample_at(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy);
      sample_expect_type probe;
      probe = predict_sample(cx, cy);
      if (!probe.unwritten)
         send_item(ACTION_SAMPLE, COL_BITS'($urandom_range(255)), ROW_BITS'($urandom_range(255)),
                   PIX_BITS'($urandom_range(255)), cx, cy);
   endtask

   task automatic settle_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [CSR_DATA_BITS-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_BITS'({index, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (index)
         REG_IMAGE_WIDTH: cfg_width = value[SIZE_BITS-1:0];
         REG_IMAGE_HEIGHT: cfg_height = value[SIZE_BITS-1:0];
         REG_SAMPLE_MODE: cfg_mode = value[0];
         REG_OUTSIDE_VALUE: cfg_outside = value[VALUE_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(logic [SIZE_BITS-1:0] width_reg, logic [SIZE_BITS-1:0] height_reg,
                               logic mode, logic [VALUE_BITS-1:0] outside);
      settle_pipeline();
      csr_write(REG_IMAGE_WIDTH, CSR_DATA_BITS'(width_reg));
      csr_write(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(height_reg));
      csr_write(REG_SAMPLE_MODE, CSR_DATA_BITS'(mode));
      csr_write(REG_OUTSIDE_VALUE, CSR_DATA_BITS'(outside));
   endtask

   task automatic set_idling(int send_pct, int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic fill_image(int w, int h);
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++)
            write_pixel(COL_BITS'(c), ROW_BITS'(r), pick_pixel());
   endtask

   task automatic random_item();
      logic [COORD_BITS-1:0] cx, cy;
      sample_expect_type probe;
      int w, h, tries;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      if ($urandom_range(99) < 15) begin
         if ($urandom_range(1))
            write_pixel(COL_BITS'($urandom_range(255)), ROW_BITS'($urandom_range(255)),
                        pick_pixel());
         else
            write_pixel(COL_BITS'($urandom_range(w > 0 ? w - 1 : 0)),
                        ROW_BITS'($urandom_range(h > 0 ? h - 1 : 0)), pick_pixel());
      end else begin
         tries = 0;
         do begin
            cx = pick_coord(w);
            cy = pick_coord(h);
            probe = predict_sample(cx, cy);
            tries++;
         end while (probe.unwritten && tries < 32);
         if (probe.unwritten) begin
            cx = '0;
            cy = '0;
         end
         sample_at(cx, cy);
      end
   endtask

   task automatic run_random_phase(logic [SIZE_BITS-1:0] width_reg,
                                   logic [SIZE_BITS-1:0] height_reg, logic mode,
                                   logic [VALUE_BITS-1:0] outside, int count);
      apply_config(width_reg, height_reg, mode, outside);
      case (phase_count % 4)
         0: set_idling(0, 0);
         1: set_idling(78, 0);
         2: set_idling(0, 78);
         default: set_idling(36, 36);
      endcase
      phase_count++;
      fill_image(eff_size(width_reg), eff_size(height_reg));
      repeat (count) random_item();
   endtask

   // reset values: full-size image, bilinear, outside value zero
   task automatic test_reset_defaults();
      set_idling(0, 0);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            write_pixel(COL_BITS'(c), ROW_BITS'(r), ((r + c) % 2) ? 8'h00 : 8'hFF);
      for (int r = 253; r < 256; r++)
         for (int c = 253; c < 256; c++)
            write_pixel(COL_BITS'(c), ROW_BITS'(r), pick_pixel());
      sample_at(q98(1, 0), q98(1, 0));
      sample_at(q98(1, 128), q98(1, 64));
      sample_at(q98(2, 255), q98(2, 255));
      sample_at(q98(1, 255), q98(2, 1));
      sample_at(q98(256, 0), q98(256, 0));
      sample_at(q98(256, 0), q98(254, 128));
      sample_at(q98(254, 77), q98(256, 0));
      sample_at(q98(255, 200), q98(255, 13));
      sample_at(q98(0, 255), q98(1, 0));
      sample_at(q98(256, 1), q98(256, 0));
      sample_at(q98(1, 0), q98(256, 1));
      sample_at(17'h1FFFF, 17'h1FFFF);
      sample_at('0, '0);
   endtask

   // nearest mode: halves round up, rounding can move a point in or out
   task automatic test_nearest_rounding();
      settle_pipeline();
      csr_write(REG_SAMPLE_MODE, CSR_DATA_BITS'(MODE_NEAREST));
      csr_write(REG_OUTSIDE_VALUE, 32'h0000FFFF);
      sample_at(q98(0, 127), q98(1, 0));
      sample_at(q98(0, 128), q98(1, 0));
      sample_at(q98(1, 127), q98(1, 128));
      sample_at(q98(2, 128), q98(3, 127));
      sample_at(q98(256, 127), q98(256, 127));
      sample_at(q98(256, 128), q98(256, 0));
      sample_at(q98(255, 128), q98(254, 200));
      sample_at(17'h1FFFF, q98(1, 0));
   endtask

   // zero size, single pixel and saturating size registers
   task automatic test_degenerate_sizes();
      apply_config(9'd0, 9'd5, MODE_BILINEAR, VALUE_BITS'($urandom_range(65535)));
      repeat (20) random_item();
      settle_pipeline();
      csr_write(REG_SAMPLE_MODE, CSR_DATA_BITS'(MODE_NEAREST));
      repeat (20) random_item();
      apply_config(9'd1, 9'd1, MODE_BILINEAR, 16'hFFFF);
      write_pixel('0, '0, pick_pixel());
      sample_at(q98(1, 0), q98(1, 0));
      sample_at(q98(1, 1), q98(1, 0));
      sample_at(q98(1, 0), q98(0, 255));
      settle_pipeline();
      csr_write(REG_SAMPLE_MODE, CSR_DATA_BITS'(MODE_NEAREST));
      sample_at(q98(1, 127), q98(0, 128));
      sample_at(q98(1, 128), q98(1, 0));
      run_random_phase(9'd511, 9'd1, MODE_BILINEAR, VALUE_BITS'($urandom_range(65535)), 60);
      run_random_phase(9'd1, 9'd511, MODE_NEAREST, VALUE_BITS'($urandom_range(65535)), 60);
      run_random_phase(9'd256, 9'd0, MODE_NEAREST, 16'h0000, 30);
   endtask

   task automatic test_random_bilinear();
      run_random_phase(9'd4, 9'd4, MODE_BILINEAR, VALUE_BITS'($urandom_range(65535)), 60);
      run_random_phase(9'd24, 9'd2, MODE_BILINEAR, 16'hFFFF, 60);
      run_random_phase(9'd17, 9'd9, MODE_BILINEAR, VALUE_BITS'($urandom_range(65535)), 60);
      run_random_phase(9'd12, 9'd8, MODE_BILINEAR, 16'h0000, 60);
   endtask

   task automatic test_random_nearest();
      run_random_phase(9'd2, 9'd24, MODE_NEAREST, VALUE_BITS'($urandom_range(65535)), 60);
      run_random_phase(9'd8, 9'd8, MODE_NEAREST, 16'hFFFF, 60);
      run_random_phase(9'd5, 9'd3, MODE_NEAREST, VALUE_BITS'($urandom_range(65535)), 60);
      run_random_phase(9'd16, 9'd4, MODE_NEAREST, VALUE_BITS'($urandom_range(65535)), 60);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_nearest_rounding();
      test_degenerate_sizes();
      test_random_bilinear();
      test_random_nearest();
      settle_pipeline();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
